@@ hdl/olpsd_pkg.sv @@
// Shared constants, codes and types for the ordered list core.
package olpsd_pkg;

   // Store size and derived widths
   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   // Result field widths
   localparam int RSP_POS_W   = 4;
   localparam int RSP_COUNT_W = 5;

   // Operation codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Control broadcast to every cell of the row
   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

@@ hdl/olpsd_cell.sv @@
// One entry of the ordered list: holds a value, compares it and shifts with its neighbours.
module olpsd_cell (
   input  logic                          clock,
   input  olpsd_pkg::cell_ctrl_type      ctrl,
   input  logic                          occupied,
   input  logic [olpsd_pkg::DATA_W-1:0]  prev_data,
   input  logic [olpsd_pkg::DATA_W-1:0]  next_data,
   input  logic                          hit_in,
   output logic [olpsd_pkg::DATA_W-1:0]  data,
   output logic                          first,
   output logic                          hit_out
);
   import olpsd_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              match;

   // Compare the held entry against the broadcast value
   assign match   = occupied && (data_ff == ctrl.value);
   assign first   = match && !hit_in;
   assign hit_out = hit_in || match;
   assign data    = data_ff;

   // Shift back on insert, pull forward from the first match onward on delete
   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         data_in = prev_data;
      end else if (ctrl.remove && hit_out) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ hdl/ordered_list_push_search_delete_core.sv @@
// Top level of the ordered list core: command handshake, count and the row of entry cells.
//
//   channel   ports                                          direction  handshake
//   request   start, busy, req_action, req_value             in         start && !busy
//   result    rsp_strobe, rsp_status, rsp_found,             out        rsp_strobe, one cycle
//             rsp_position, rsp_count
//
// An item is taken when start is high and busy is low. Busy is then high for the execute
// state, in which every cell compares its entry with the value, the first-match chain
// runs down the row and the shift is applied; the result strobes in the cycle after.
// A new item may be taken in the same cycle as the result strobe, so one item per two
// cycles. Reset empties the list at once; the receiver cannot stall the result.
module ordered_list_push_search_delete_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic signed [olpsd_pkg::DATA_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_found,
   output logic [olpsd_pkg::RSP_POS_W-1:0]      rsp_position,
   output logic [olpsd_pkg::RSP_COUNT_W-1:0]    rsp_count
);
   import olpsd_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                   state_ff;
   logic                   state_in;
   logic [1:0]             action_ff;
   logic [DATA_W-1:0]      value_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic                   strobe_ff;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic                   found_ff;
   logic                   found_in;
   logic [RSP_POS_W-1:0]   position_ff;
   logic [RSP_POS_W-1:0]   position_in;

   cell_ctrl_type          ctrl;
   logic [DATA_W-1:0]      cell_data [CAPACITY];
   logic [CAPACITY-1:0]    occupied;
   logic [CAPACITY-1:0]    first;
   logic [CAPACITY:0]      hit;
   logic                   accept;
   logic                   exec;
   logic                   is_full;
   logic                   is_empty;
   logic                   any_hit;
   logic [RSP_POS_W-1:0]   hit_pos;

   assign accept   = start && (state_ff == S_IDLE);
   assign exec     = (state_ff == S_EXEC);
   assign busy     = exec;
   assign is_full  = (count_ff >= COUNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign any_hit  = hit[CAPACITY];

   // Drive the row
   assign ctrl.value  = value_ff;
   assign ctrl.insert = exec && (action_ff == ACT_INSERT) && !is_full;
   assign ctrl.remove = exec && (action_ff == ACT_DELETE) && any_hit;
   assign hit[0]      = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_data;
      logic [DATA_W-1:0] next_data;

      assign occupied[i] = (COUNT_W'(i) < count_ff);
      if (i == 0) begin : g_front
         assign prev_data = value_ff;
      end else begin : g_prev
         assign prev_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign next_data = cell_data[i];
      end else begin : g_next
         assign next_data = cell_data[i+1];
      end

      olpsd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied[i]),
         .prev_data (prev_data),
         .next_data (next_data),
         .hit_in    (hit[i]),
         .data      (cell_data[i]),
         .first     (first[i]),
         .hit_out   (hit[i+1])
      );
   end

   // Encode the position of the single first-match cell
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first[i]) begin
            hit_pos = hit_pos | RSP_POS_W'(i);
         end
      end
   end

   // Form the result and the new count
   always_comb begin
      status_in   = ST_OK;
      found_in    = 1'b0;
      position_in = '0;
      count_in    = count_ff;
      case (action_ff)
         ACT_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_SEARCH, ACT_DELETE: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (!any_hit) begin
               status_in = ST_NOT_FOUND;
            end else begin
               found_in    = 1'b1;
               position_in = hit_pos;
               if (action_ff == ACT_DELETE) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= exec;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the accepted item and the result
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
      if (exec) begin
         status_ff   <= status_in;
         found_ff    <= found_in;
         position_ff <= position_in;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = RSP_COUNT_W'(count_ff);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the ordered list core: commands checked against a software list.
module tb;
   import olpsd_pkg::*;

   // Action code three has no name in the package; the core ignores it
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_COMMANDS = 475;

   typedef struct packed {
      logic [1:0]             status;
      logic                   found;
      logic [RSP_POS_W-1:0]   position;
      logic [RSP_COUNT_W-1:0] count;
   } reply_type;

   // Software copy of the list and the queue of replies it predicts
   class list_tracker;
      logic [DATA_W-1:0] held[$];
      reply_type         pending_replies[$];
      int mismatches, checked, peak;
      int n_insert, n_search, n_delete, n_unused, n_full, n_empty, n_miss, n_hit;

      // Apply one accepted command to the list and queue its reply
      function void take_command(logic [1:0] action, logic [DATA_W-1:0] value);
         reply_type r;
         int        where;
         r     = '0;
         where = -1;
         case (action)
            ACT_INSERT: begin
               n_insert++;
               if (held.size() >= CAPACITY) begin
                  r.status = ST_FULL;
                  n_full++;
               end else begin
                  held.push_front(value);
               end
            end
            ACT_SEARCH, ACT_DELETE: begin
               if (action == ACT_SEARCH) n_search++;
               else n_delete++;
               if (held.size() == 0) begin
                  r.status = ST_EMPTY;
                  n_empty++;
               end else begin
                  // the front entry wins among equal values
                  foreach (held[i]) begin
                     if (where < 0 && held[i] == value) where = i;
                  end
                  if (where < 0) begin
                     r.status = ST_NOT_FOUND;
                     n_miss++;
                  end else begin
                     r.found    = 1'b1;
                     r.position = where[RSP_POS_W-1:0];
                     n_hit++;
                     if (action == ACT_DELETE) held.delete(where);
                  end
               end
            end
            default: n_unused++;
         endcase
         r.count = RSP_COUNT_W'(held.size());
         if (held.size() > peak) peak = held.size();
         pending_replies.push_back(r);
      endfunction

      // Compare one reply from the core with the oldest prediction
      function void check_reply(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: status %0d found %0d pos %0d count %0d",
                        got.status, got.found, got.position, got.count);
            return;
         end
         want = pending_replies.pop_front();
         checked++;
         if (got.status !== want.status || got.found !== want.found ||
             got.position !== want.position || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"reply %0d: want status %0d found %0d pos %0d count %0d, ",
                         "got %0d %0d %0d %0d"},
                        checked, want.status, want.found, want.position, want.count,
                        got.status, got.found, got.position, got.count);
         end
      endfunction

      // Draw one value the list currently holds
      function logic [DATA_W-1:0] pick_held();
         return held[$urandom_range(0, held.size() - 1)];
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [1:0]                      req_action = ACT_INSERT;
   logic signed [DATA_W-1:0]        req_value = '0;
   logic                            rsp_strobe;
   logic [1:0]                      rsp_status;
   logic                            rsp_found;
   logic [RSP_POS_W-1:0]            rsp_position;
   logic [RSP_COUNT_W-1:0]          rsp_count;

   list_tracker lists = new();
   int          burst_left = 0;

   ordered_list_push_search_delete_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hand one item to the core and hold it until taken
   task automatic send_command(input logic [1:0] action, input logic [DATA_W-1:0] value);
      start      <= 1'b1;
      req_action <= action;
      req_value  <= value;
      do @(posedge clock); while (busy);
      lists.take_command(action, value);
   endtask

   // Close the current burst with a random gap, or carry on back to back
   task automatic idle_between_bursts();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Values at the edges of the range and near zero, so that matches are frequent
   function automatic logic [DATA_W-1:0] edge_value();
      case ($urandom_range(0, 6))
         0: return 32'hFFFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         5: return 32'h0000_0002;
         default: return 32'hFFFF_FFFE;
      endcase
   endfunction

   // Check every reply the core strobes
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         lists.check_reply('{rsp_status, rsp_found, rsp_position, rsp_count});
   end

   // Stimulus, drain and verdict
   initial begin
      logic [DATA_W-1:0] fill_values[16];
      logic [1:0]        action;
      logic [DATA_W-1:0] value;
      int                mode, phase_left, real_items, draw, drain;
      fill_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0007, 32'h0000_0001,
                      32'h0000_0007, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                      32'h0000_0002, 32'hFFFF_FFFE, 32'h1234_5678, 32'h0000_0007};
      phase_left = 0;
      real_items = 0;
      mode       = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty list: search, delete and the ignored code
      send_command(ACT_SEARCH, 32'h0000_0001);
      send_command(ACT_DELETE, 32'h0000_0001);
      send_command(ACT_UNUSED, 32'h0000_0000);
      // Fill to capacity, then push once more into the full list
      foreach (fill_values[i]) begin
         send_command(ACT_INSERT, fill_values[i]);
         idle_between_bursts();
      end
      send_command(ACT_INSERT, 32'h1234_5678);
      // Duplicates, the back entry, a miss and the ignored code with a count one below capacity
      send_command(ACT_SEARCH, 32'h0000_0007);
      send_command(ACT_SEARCH, 32'h8000_0000);
      send_command(ACT_DELETE, 32'h8000_0000);
      send_command(ACT_DELETE, 32'h0BAD_F00D);
      send_command(ACT_UNUSED, 32'hFFFF_FFFF);

      // Random phases that grow, shrink or churn the list
      while (real_items < RANDOM_COMMANDS) begin
         if (phase_left == 0) begin
            mode       = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 60);
         end
         draw = $urandom_range(0, 99);
         case (mode)
            0: action = (draw < 70) ? ACT_INSERT : (draw < 82) ? ACT_SEARCH :
                        (draw < 95) ? ACT_DELETE : ACT_UNUSED;
            1: action = (draw < 15) ? ACT_INSERT : (draw < 40) ? ACT_SEARCH :
                        (draw < 95) ? ACT_DELETE : ACT_UNUSED;
            default: action = (draw < 35) ? ACT_INSERT : (draw < 65) ? ACT_SEARCH :
                              (draw < 95) ? ACT_DELETE : ACT_UNUSED;
         endcase
         draw = $urandom_range(0, 99);
         if (action == ACT_SEARCH || action == ACT_DELETE) begin
            if (draw < 60 && lists.held.size() > 0) value = lists.pick_held();
            else if (draw < 85) value = edge_value();
            else value = $urandom;
         end else begin
            value = (draw < 50) ? edge_value() : $urandom;
         end
         send_command(action, value);
         if (action != ACT_UNUSED) real_items++;
         phase_left--;
         idle_between_bursts();
      end

      // Drain outstanding replies, then watch for stray replies before the verdict
      start <= 1'b0;
      drain = 0;
      while (lists.pending_replies.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (lists.pending_replies.size() != 0) begin
         lists.mismatches++;
         $display("%0d replies never arrived", lists.pending_replies.size());
      end

      $display("commands: %0d insert, %0d search, %0d delete, %0d ignored; %0d replies checked",
               lists.n_insert, lists.n_search, lists.n_delete, lists.n_unused, lists.checked);
      $display("outcomes: %0d full, %0d empty, %0d missed, %0d matched; deepest list %0d",
               lists.n_full, lists.n_empty, lists.n_miss, lists.n_hit, lists.peak);
      if (lists.mismatches == 0) begin
         $display("ordered_list_push_search_delete_core: match");
      end else begin
         $display("ordered_list_push_search_delete_core: mismatch");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("ordered_list_push_search_delete_core: mismatch");
      $finish;
   end

endmodule
